[rtl/assert_macros.svh]
// Assertion helpers for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define CRT_ASSERT_ALWAYS(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (cond)) \
    else $error("invariant violated");

// A condition that, once seen, forces a consequence in the next cycle.
`define CRT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("next-cycle check violated");

`endif

[rtl/crt_pkg.sv]
package crt_pkg;

  // Field widths of the item channels and the register file.
  localparam int SIZE_W    = 13;
  localparam int COUNT_W   = 9;
  localparam int ID_W      = 16;
  localparam int ID_EXT_W  = 17;
  localparam int RADDR_W   = 12;
  localparam int POS_W     = 13;
  localparam int BASE_W    = 29;
  localparam int ADDR_W    = 30;
  localparam int PDATA_W   = 32;
  localparam int PADDR_W   = 4;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Result buffer sizing.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  // Register indexes.
  localparam logic [1:0] REG_CHUNK_SIZE  = 2'd0;
  localparam logic [1:0] REG_CHUNK_COUNT = 2'd1;
  localparam logic [1:0] REG_LAST_SIZE   = 2'd2;

  // Input actions and result kinds.
  localparam logic ACT_DELIVER = 1'b0;
  localparam logic ACT_READ    = 1'b1;
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_MISMATCH,
    STATUS_RANGE
  } status_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  chunk_size;
    logic [COUNT_W-1:0] chunk_count;
    logic [SIZE_W-1:0]  last_chunk_size;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    status_t            status;
    logic               complete;
    logic [COUNT_W-1:0] received_chunks;
    logic [7:0]         read_data;
  } res_t;

endpackage

[rtl/chunk_reassembly_tracker.sv]
// A result item passes stage 1, stage 2, stage 3 and the result buffer before out_valid offers it.
// Throughput: one input item per cycle, set by the blob memory written at most once per item.
// A small result buffer keeps full rate; in_ready drops when results back up or while clearing.
// Reset is synchronous and active low; afterwards a pass over all MAX_CHUNKS entries clears the
// chunk bitmap memory, during which no input item is accepted (register writes still work).
`include "assert_macros.svh"

module chunk_reassembly_tracker
  import crt_pkg::*;
#(
  parameter int MAX_OCTETS = 4096,
  parameter int MAX_CHUNKS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input item channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [ID_W-1:0]    in_chunk_id,
  input  logic [7:0]         in_octet,
  input  logic               in_last_octet,
  input  logic [RADDR_W-1:0] in_read_address,
  // Result item channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [1:0]         out_status,
  output logic               out_complete,
  output logic [COUNT_W-1:0] out_received_chunks,
  output logic [7:0]         out_read_data,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int BLOB_AW = $clog2(MAX_OCTETS);
  localparam int SEEN_AW = $clog2(MAX_CHUNKS);

  cfg_t cfg;

  crt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Usable chunk count is the register limited to the bitmap depth.
  logic [ID_EXT_W-1:0] limit;
  assign limit = (ID_EXT_W'(cfg.chunk_count) < ID_EXT_W'(MAX_CHUNKS)) ?
                 ID_EXT_W'(cfg.chunk_count) : ID_EXT_W'(MAX_CHUNKS);

  // Control state.
  logic               clr_r;
  logic [SEEN_AW-1:0] clr_cnt_r;
  logic [POS_W-1:0]   pos_r;
  logic [COUNT_W-1:0] seen_cnt_r;
  logic [COUNT_W-1:0] seen_cnt_nxt;
  logic               all_r;
  logic               all_nxt;
  logic               s1_v_r;
  logic               s2_v_r;
  logic               s3_v_r;
  logic               s3_v_nxt;

  // Stage 1 payload.
  logic               s1_act_r;
  logic [ID_W-1:0]    s1_id_r;
  logic [7:0]         s1_octet_r;
  logic               s1_last_r;
  logic [RADDR_W-1:0] s1_raddr_r;
  logic [POS_W-1:0]   s1_pos_r;

  // Stage 2 payload.
  logic               s2_act_r;
  logic [7:0]         s2_octet_r;
  logic               s2_last_r;
  logic [RADDR_W-1:0] s2_raddr_r;
  logic [POS_W-1:0]   s2_pos_r;
  logic [BASE_W-1:0]  s2_base_r;
  logic               s2_inr_r;
  logic [SIZE_W-1:0]  s2_exp_r;
  logic               s2_fwd_r;
  logic [SEEN_AW-1:0] s2_sidx_r;

  // Stage 3 payload.
  res_t               s3_res_r;
  res_t               s3_res_nxt;
  logic               s3_rok_r;

  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic [FIFO_CNT_W-1:0] credit;
  logic                  accept;

  // Items in flight plus buffered results must fit the result buffer.
  assign credit = fifo_cnt + FIFO_CNT_W'(s1_v_r) + FIFO_CNT_W'(s2_v_r)
                + FIFO_CNT_W'(s3_v_r);
  assign in_ready = !clr_r && (credit < FIFO_CNT_W'(FIFO_DEPTH));
  assign accept   = in_valid && in_ready;

  // Stage 1: range check, expected size and chunk base address.
  logic               s1_inr;
  logic               s1_final;
  logic [SIZE_W-1:0]  s1_exp;
  logic [BASE_W-1:0]  s1_base;
  logic               s1_fwd;

  assign s1_inr   = ID_EXT_W'(s1_id_r) < limit;
  assign s1_final = (ID_EXT_W'(s1_id_r) + ID_EXT_W'(1)) == limit;
  assign s1_exp   = s1_final ? cfg.last_chunk_size : cfg.chunk_size;
  assign s1_base  = BASE_W'(s1_id_r) * BASE_W'(cfg.chunk_size);

  // Stage 2: address, drop checks, size check and bitmap update.
  logic               seen_rdata;
  logic               seen_bit;
  logic               seen_wr;
  logic               s2_close;
  logic [ADDR_W-1:0]  s2_addr;
  logic [ADDR_W-1:0]  s2_end;
  logic [POS_W:0]     s2_delivered;
  logic               s2_addr_ok;
  logic               s2_pos_ok;
  logic               s2_mismatch;
  logic               blob_we;
  logic               blob_re;
  logic [7:0]         blob_rdata;
  status_t            s2_status;

  assign s2_close     = s2_v_r && (s2_act_r == ACT_DELIVER) && s2_last_r && s2_inr_r;
  assign seen_bit     = s2_fwd_r || seen_rdata;
  assign seen_wr      = s2_close && !seen_bit;
  assign s2_addr      = ADDR_W'(s2_base_r) + ADDR_W'(s2_pos_r);
  assign s2_delivered = {1'b0, s2_pos_r} + (POS_W+1)'(1);
  assign s2_end       = ADDR_W'(s2_base_r) + ADDR_W'(s2_delivered);
  assign s2_addr_ok   = s2_addr < ADDR_W'(MAX_OCTETS);
  assign s2_pos_ok    = s2_pos_r < s2_exp_r;
  assign s2_mismatch  = (s2_delivered != (POS_W+1)'(s2_exp_r))
                     || (s2_end > ADDR_W'(MAX_OCTETS));
  assign blob_we      = s2_v_r && (s2_act_r == ACT_DELIVER) && s2_inr_r
                     && s2_pos_ok && s2_addr_ok;
  assign blob_re      = s2_v_r && (s2_act_r == ACT_READ);

  // A chunk closed in stage 2 while stage 1 reads the same bitmap entry.
  assign s1_fwd = seen_wr && (s2_sidx_r == SEEN_AW'(s1_id_r));

  always_comb begin
    seen_cnt_nxt = seen_cnt_r + COUNT_W'(seen_wr);
    all_nxt      = all_r;
    if (s2_close && (limit != '0) && (ID_EXT_W'(seen_cnt_nxt) >= limit)) begin
      all_nxt = 1'b1;
    end
    if (!s2_inr_r) begin
      s2_status = STATUS_RANGE;
    end else if (s2_mismatch) begin
      s2_status = STATUS_MISMATCH;
    end else begin
      s2_status = STATUS_OK;
    end
    s3_v_nxt = s2_v_r && ((s2_act_r == ACT_READ) || s2_last_r);
    s3_res_nxt.kind            = (s2_act_r == ACT_READ) ? KIND_READ : KIND_STATUS;
    s3_res_nxt.status          = (s2_act_r == ACT_READ) ? STATUS_OK : s2_status;
    s3_res_nxt.complete        = all_nxt;
    s3_res_nxt.received_chunks = seen_cnt_nxt;
    s3_res_nxt.read_data       = '0;
  end

  // Chunk bitmap memory, cleared by a sweep after reset.
  logic               seen_we;
  logic [SEEN_AW-1:0] seen_waddr;

  assign seen_we    = clr_r || seen_wr;
  assign seen_waddr = clr_r ? clr_cnt_r : s2_sidx_r;

  crt_ram #(
    .WIDTH (1),
    .DEPTH (MAX_CHUNKS)
  ) u_seen_ram (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (!clr_r),
    .re    (s1_v_r),
    .raddr (SEEN_AW'(s1_id_r)),
    .rdata (seen_rdata)
  );

  // Blob memory: delivered octets in, read octets out.
  crt_ram #(
    .WIDTH (8),
    .DEPTH (MAX_OCTETS)
  ) u_blob_ram (
    .clk   (clk),
    .we    (blob_we),
    .waddr (s2_addr[BLOB_AW-1:0]),
    .wdata (s2_octet_r),
    .re    (blob_re),
    .raddr (BLOB_AW'(s2_raddr_r)),
    .rdata (blob_rdata)
  );

  // Control registers of the pipeline and tracker state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_cnt_r  <= '0;
      pos_r      <= '0;
      seen_cnt_r <= '0;
      all_r      <= 1'b0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + SEEN_AW'(1);
        if (clr_cnt_r == SEEN_AW'(MAX_CHUNKS - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (accept && (in_action == ACT_DELIVER)) begin
        if (in_last_octet) begin
          pos_r <= '0;
        end else if (pos_r != POS_MAX) begin
          pos_r <= pos_r + POS_W'(1);
        end
      end
      seen_cnt_r <= seen_cnt_nxt;
      all_r      <= all_nxt;
      s1_v_r     <= accept;
      s2_v_r     <= s1_v_r;
      s3_v_r     <= s3_v_nxt;
    end
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act_r   <= in_action;
      s1_id_r    <= in_chunk_id;
      s1_octet_r <= in_octet;
      s1_last_r  <= in_last_octet;
      s1_raddr_r <= in_read_address;
      s1_pos_r   <= pos_r;
    end
    s2_act_r   <= s1_act_r;
    s2_octet_r <= s1_octet_r;
    s2_last_r  <= s1_last_r;
    s2_raddr_r <= s1_raddr_r;
    s2_pos_r   <= s1_pos_r;
    s2_base_r  <= s1_base;
    s2_inr_r   <= s1_inr;
    s2_exp_r   <= s1_exp;
    s2_fwd_r   <= s1_fwd;
    s2_sidx_r  <= SEEN_AW'(s1_id_r);
    s3_res_r   <= s3_res_nxt;
    s3_rok_r   <= ADDR_W'(s2_raddr_r) < ADDR_W'(MAX_OCTETS);
  end

  // Stage 3: attach read data and hand the result item to the buffer.
  res_t push_data;
  res_t out_data;

  always_comb begin
    push_data = s3_res_r;
    if ((s3_res_r.kind == KIND_READ) && s3_rok_r) begin
      push_data.read_data = blob_rdata;
    end
  end

  crt_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s3_v_r),
    .push_data (push_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .count     (fifo_cnt)
  );

  assign out_kind            = out_data.kind;
  assign out_status          = out_data.status;
  assign out_complete        = out_data.complete;
  assign out_received_chunks = out_data.received_chunks;
  assign out_read_data       = out_data.read_data;

  // The credit scheme never lets the result buffer overflow.
  `CRT_ASSERT_ALWAYS(a_credit_fits, clk, rst_n, credit <= FIFO_CNT_W'(FIFO_DEPTH))
  // A chunk closed right after the same chunk must not be counted twice.
  `CRT_ASSERT_NEXT(a_fwd_no_count, clk, rst_n, s2_close && s2_fwd_r, $stable(seen_cnt_r))
  // The complete flag is sticky.
  `CRT_ASSERT_NEXT(a_complete_sticky, clk, rst_n, all_r, all_r)

endmodule

[rtl/crt_ram.sv]
module crt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/crt_cfg.sv]
module crt_cfg
  import crt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes land in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chunk_size      <= SIZE_W'(1024);
      cfg_r.chunk_count     <= COUNT_W'(4);
      cfg_r.last_chunk_size <= SIZE_W'(1024);
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_CHUNK_SIZE:  cfg_r.chunk_size      <= pwdata[SIZE_W-1:0];
        REG_CHUNK_COUNT: cfg_r.chunk_count     <= pwdata[COUNT_W-1:0];
        REG_LAST_SIZE:   cfg_r.last_chunk_size <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register.
  always_comb begin
    case (paddr[3:2])
      REG_CHUNK_SIZE:  prdata = PDATA_W'(cfg_r.chunk_size);
      REG_CHUNK_COUNT: prdata = PDATA_W'(cfg_r.chunk_count);
      REG_LAST_SIZE:   prdata = PDATA_W'(cfg_r.last_chunk_size);
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

[rtl/crt_out_fifo.sv]
module crt_out_fifo
  import crt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  res_t                  push_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output res_t                  out_data,
  output logic [FIFO_CNT_W-1:0] count
);

  res_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic [FIFO_CNT_W-1:0] cnt_nxt;
  logic                  pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[rd_ptr_r];
  assign count     = cnt_r;

  // Occupancy moves by one on a lone push or a lone pop.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - FIFO_CNT_W'(1);
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
